// File: rtl/lpf_pkg.sv
// Shared types and constants for the subdivided first-order low-pass filter.
// Used by every module of the block; depends on nothing.
package lpf_pkg;

  localparam int OUT_BITS     = 24;
  localparam int SUB_BITS     = 7;
  localparam int SUB_CNT_BITS = 6;
  localparam int PAD_BITS     = 12;
  localparam int IDX_BITS     = 2;
  localparam int MAX_SUB      = 64;
  localparam int DECAY_Q18    = 253551;
  localparam int GAIN_Q18     = 5729;
  localparam int SUB_RESET    = 1;
  localparam int PAD_RESET    = 200;

  localparam logic [IDX_BITS-1:0] REG_DECAY = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_GAIN  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_SUB   = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_PAD   = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // take the sample of the accepted item
    logic load;       // preload the integral with the sample
    logic clear_sum;  // start a new bin sum
    logic mul;        // form the products of one sub-step
    logic upd;        // fold products into the integral
    logic sum_add;    // add the integral to the bin sum
    logic emit;       // round, saturate and present the result
  } lpf_cmd_t;

  typedef struct packed {
    logic out_busy;   // output register holds a result not yet taken
  } lpf_stat_t;

endpackage

// File: rtl/lpf_regs.sv
// Configuration register file: decay, gain, sub-step count and padding bins.
// Depends on lpf_pkg.
module lpf_regs import lpf_pkg::*; #(
  parameter int COEF_FRAC_BITS = 18
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IDX_BITS-1:0]       cfg_index,
  input  logic [COEF_FRAC_BITS-1:0] cfg_data,
  output logic [COEF_FRAC_BITS-1:0] decay,
  output logic [COEF_FRAC_BITS-1:0] gain,
  output logic [SUB_BITS-1:0]       sub_steps,
  output logic [PAD_BITS-1:0]       pad_bins
);

  localparam int F = COEF_FRAC_BITS;
  // reset coefficients are given in Q0.18; rescale to the configured precision
  localparam logic [63:0] DECAY_RST64 = (F >= 18) ? (64'(DECAY_Q18) << (F - 18))
                                                  : (64'(DECAY_Q18) >> (18 - F));
  localparam logic [63:0] GAIN_RST64  = (F >= 18) ? (64'(GAIN_Q18) << (F - 18))
                                                  : (64'(GAIN_Q18) >> (18 - F));

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay     <= DECAY_RST64[F-1:0];
      gain      <= GAIN_RST64[F-1:0];
      sub_steps <= SUB_BITS'(SUB_RESET);
      pad_bins  <= PAD_BITS'(PAD_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DECAY: decay     <= cfg_data;
        REG_GAIN:  gain      <= cfg_data;
        REG_SUB:   sub_steps <= cfg_data[SUB_BITS-1:0];
        REG_PAD:   pad_bins  <= cfg_data[PAD_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/lpf_ctrl.sv
// Controller: sequences padding bins and sub-steps, issues datapath commands.
// Depends on lpf_pkg.
module lpf_ctrl import lpf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                start_of_pulse,
  input  logic [SUB_BITS-1:0] sub_steps,
  input  logic [PAD_BITS-1:0] pad_bins,
  input  lpf_stat_t           stat,
  output lpf_cmd_t            cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                  state, state_next;
  logic [PAD_BITS-1:0]     pad_left, pad_left_next;
  logic [SUB_CNT_BITS-1:0] sub_cnt, sub_cnt_next;
  logic [SUB_CNT_BITS-1:0] sub_last;
  logic                    accept;

  // zero sub-steps acts as one, more than the maximum clamps
  always_comb begin
    if (sub_steps <= SUB_BITS'(1)) begin
      sub_last = '0;
    end else if (sub_steps > SUB_BITS'(MAX_SUB)) begin
      sub_last = SUB_CNT_BITS'(MAX_SUB - 1);
    end else begin
      sub_last = SUB_CNT_BITS'(sub_steps - SUB_BITS'(1));
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    pad_left_next = pad_left;
    sub_cnt_next  = sub_cnt;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture   = 1'b1;
          cmd.load      = start_of_pulse;
          cmd.clear_sum = 1'b1;
          pad_left_next = start_of_pulse ? pad_bins : '0;
          sub_cnt_next  = '0;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul     = 1'b1;
        // fold the previous sub-step's integral into the output bin
        cmd.sum_add = (pad_left == '0) && (sub_cnt != '0);
        state_next  = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (sub_cnt == sub_last) begin
          sub_cnt_next = '0;
          if (pad_left != '0) begin
            pad_left_next = pad_left - PAD_BITS'(1);
            state_next    = ST_MUL;
          end else begin
            state_next = ST_SUM;
          end
        end else begin
          sub_cnt_next = sub_cnt + SUB_CNT_BITS'(1);
          state_next   = ST_MUL;
        end
      end
      ST_SUM: begin
        cmd.sum_add = 1'b1;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pad_left <= '0;
      sub_cnt  <= '0;
    end else begin
      state    <= state_next;
      pad_left <= pad_left_next;
      sub_cnt  <= sub_cnt_next;
    end
  end

endmodule

// File: rtl/lpf_dp.sv
// Datapath: split integral-times-decay multiply, sample weighting, integral
// and bin-sum registers, rounding and output register. Depends on lpf_pkg.
module lpf_dp import lpf_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lpf_cmd_t                     cmd,
  output lpf_stat_t                    stat,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [COEF_FRAC_BITS-1:0]    decay,
  input  logic [COEF_FRAC_BITS-1:0]    gain,
  output logic signed [OUT_BITS-1:0]   filtered,
  output logic                         saturated,
  output logic                         out_valid,
  input  logic                         out_ready
);

  localparam int F   = COEF_FRAC_BITS;
  localparam int S   = SAMPLE_BITS;
  localparam int A   = S + F + 6;            // integral width
  localparam int VW  = A + 2;                // pre-saturation integral sum
  localparam int SW  = A + 6;                // bin sum over up to 64 sub-steps
  localparam int RW  = (SW + 1 - F > OUT_BITS) ? SW + 1 - F : OUT_BITS + 1;

  localparam logic signed [VW-1:0] ACC_MAX = {3'b000, {(A-1){1'b1}}};
  localparam logic signed [VW-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [RW-1:0] OUT_MAX = RW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] OUT_MIN = ~OUT_MAX;

  logic signed [S-1:0]     smp;
  logic signed [A-1:0]     acc;
  logic signed [SW-1:0]    sum;
  logic signed [A:0]       p_hi;
  logic [F:0]              p_lo;
  logic signed [S+F:0]     p_in;
  logic [2*F:0]            lo_full;
  logic signed [VW-1:0]    v;
  logic signed [VW-1:0]    v_sat;
  logic signed [SW:0]      rsum;
  logic signed [RW+F-1:0]  rsum_ext;
  logic signed [RW-1:0]    r;
  logic signed [OUT_BITS-1:0] res;
  logic                    clip;

  assign stat.out_busy = out_valid && !out_ready;

  // low half product, rounded half up
  assign lo_full = (2*F+1)'(acc[F-1:0]) * (2*F+1)'(decay)
                   + ((2*F+1)'(1) << (F - 1));

  always_comb begin
    v = VW'(p_hi) + VW'($signed({1'b0, p_lo})) + VW'(p_in);
    if (v > ACC_MAX) begin
      v_sat = ACC_MAX;
    end else if (v < ACC_MIN) begin
      v_sat = ACC_MIN;
    end else begin
      v_sat = v;
    end
  end

  always_comb begin
    // add one half of the integer step, then floor
    rsum     = (SW+1)'(sum) + ((SW+1)'(1) << (F - 1));
    rsum_ext = (RW+F)'(rsum);
    r        = RW'(rsum_ext >>> F);
    clip     = 1'b0;
    if (r > OUT_MAX) begin
      res  = OUT_MAX[OUT_BITS-1:0];
      clip = 1'b1;
    end else if (r < OUT_MIN) begin
      res  = OUT_MIN[OUT_BITS-1:0];
      clip = 1'b1;
    end else begin
      res = r[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp <= sample;
    end
    if (cmd.mul) begin
      p_hi <= $signed(acc[A-1:F]) * $signed({1'b0, decay});
      p_lo <= lo_full[2*F:F];
      p_in <= smp * $signed({1'b0, gain});
    end
    if (cmd.clear_sum) begin
      sum <= '0;
    end else if (cmd.sum_add) begin
      sum <= sum + SW'(acc);
    end
    if (cmd.emit) begin
      filtered  <= res;
      saturated <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        acc <= {{6{sample[S-1]}}, sample, {F{1'b0}}};
      end else if (cmd.upd) begin
        acc <= v_sat[A-1:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/first_order_lowpass_subdivided.sv
// Each accepted item runs one bin of N sub-steps, N = sub-steps per bin
// (clamped to 1..64); a pulse start first adds pad_bins padding bins of N sub-steps each.
// One item at a time: a new item is taken only after the last result is emitted. Each
// sub-step uses the shared multiply state, then an integral update; then bin sum and rounding.
// Reset: synchronous; registers take their default values, integral clears to zero.
module first_order_lowpass_subdivided import lpf_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          start_of_pulse,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_BITS-1:0]    filtered,
  output logic                          saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [IDX_BITS-1:0]           cfg_index,
  input  logic [COEF_FRAC_BITS-1:0]     cfg_data
);

  logic [COEF_FRAC_BITS-1:0] decay;
  logic [COEF_FRAC_BITS-1:0] gain;
  logic [SUB_BITS-1:0]       sub_steps;
  logic [PAD_BITS-1:0]       pad_bins;
  lpf_cmd_t                  cmd;
  lpf_stat_t                 stat;

  lpf_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .decay     (decay),
    .gain      (gain),
    .sub_steps (sub_steps),
    .pad_bins  (pad_bins)
  );

  lpf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_of_pulse (start_of_pulse),
    .sub_steps      (sub_steps),
    .pad_bins       (pad_bins),
    .stat           (stat),
    .cmd            (cmd)
  );

  lpf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample    (sample),
    .decay     (decay),
    .gain      (gain),
    .filtered  (filtered),
    .saturated (saturated),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
